// ----- sv/pdr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the point distance row builder: word types, field widths and
// default sizes. Depends on nothing; the top level and the checker import it.
package pdr_pkg;

    localparam int COORD_W        = 16;
    localparam int IDX_W          = 6;
    localparam int DIST_W         = 25;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } point_t;

    typedef struct packed {
        logic [IDX_W-1:0]  other_index;
        logic [IDX_W-1:0]  new_index;
        logic [DIST_W-1:0] distance_q8;
        logic              full_error;
        logic              last;
    } result_t;

endpackage

// ----- sv/pdr_point_mem.sv -----
`timescale 1ns / 1ps
// Point store: one write port and one registered read port for x and y.
// Does not depend on pdr_pkg; no types from it are needed here.
module pdr_point_mem #(
    parameter int DEPTH = 64,
    parameter int CW    = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [CW-1:0]            wx,
    input  logic [CW-1:0]            wy,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [CW-1:0]            rx,
    output logic [CW-1:0]            ry
);

    logic [CW-1:0] x_mem [DEPTH];
    logic [CW-1:0] y_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            x_mem[waddr] <= wx;
            y_mem[waddr] <= wy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rx <= x_mem[raddr];
            ry <= y_mem[raddr];
        end
    end

endmodule

// ----- sv/pdr_sq_serial.sv -----
`timescale 1ns / 1ps
// Bit-serial sum of squares a*a + b*b, one multiplier bit of each per cycle.
// Standalone; used by the top level of the point distance row builder.
module pdr_sq_serial #(
    parameter int CW = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  logic [CW-1:0]   a,
    input  logic [CW-1:0]   b,
    output logic            done,
    output logic [2*CW:0]   sum
);

    localparam int PW    = 2 * CW;
    localparam int SW    = 2 * CW + 1;
    localparam int CNT_W = $clog2(CW + 1);

    logic [CW-1:0]    mul_a_reg, mul_a_next;
    logic [CW-1:0]    mul_b_reg, mul_b_next;
    logic [PW-1:0]    mc_a_reg, mc_a_next;
    logic [PW-1:0]    mc_b_reg, mc_b_next;
    logic [SW-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [SW-1:0]    add_a, add_b;

    always_comb
    begin
        add_a      = mul_a_reg[0] ? SW'(mc_a_reg) : '0;
        add_b      = mul_b_reg[0] ? SW'(mc_b_reg) : '0;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        mc_a_next  = mc_a_reg;
        mc_b_next  = mc_b_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (go)
        begin
            mul_a_next = a;
            mul_b_next = b;
            mc_a_next  = PW'(a);
            mc_b_next  = PW'(b);
            acc_next   = '0;
            cnt_next   = CNT_W'(CW);
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next   = acc_reg + add_a + add_b;
            mul_a_next = mul_a_reg >> 1;
            mul_b_next = mul_b_reg >> 1;
            mc_a_next  = mc_a_reg << 1;
            mc_b_next  = mc_b_reg << 1;
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        mc_a_reg  <= mc_a_next;
        mc_b_reg  <= mc_b_next;
        acc_reg   <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

// ----- sv/pdr_isqrt.sv -----
`timescale 1ns / 1ps
// Digit-serial integer square root, restoring method, one root bit per cycle.
// Standalone; used by the top level of the point distance row builder.
module pdr_isqrt #(
    parameter int IN_W = 52
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [IN_W-1:0]     rad,
    output logic                done,
    output logic [IN_W/2-1:0]   root
);

    localparam int OUT_W = IN_W / 2;
    localparam int CNT_W = $clog2(OUT_W + 1);

    logic [IN_W-1:0]  rad_reg, rad_next;
    logic [OUT_W:0]   rem_reg, rem_next;
    logic [OUT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [OUT_W+1:0] rem_sh, trial, diff;

    always_comb
    begin
        rem_sh    = {rem_reg[OUT_W-1:0], rad_reg[IN_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        diff      = rem_sh - trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(OUT_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[IN_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = diff[OUT_W:0];
                root_next = {root_reg[OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[OUT_W:0];
                root_next = {root_reg[OUT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- sv/point_distance_row_builder.sv -----
`timescale 1ns / 1ps
// Point distance row builder. Each stored point is read and differenced, then squared in pdr_sq_serial
// and rooted in pdr_isqrt (states ST_RD, ST_DIFF, ST_SQ, ST_RT), one point at a time.
// Busy stays high for the whole row; a start with the store full gives only the store-full word.
// Results appear one cycle each with strobe high; the receiver cannot stall, none is needed.
// Asynchronous active-low reset empties the store (count zero); entries need no clearing.
// Depends on pdr_pkg, pdr_point_mem, pdr_sq_serial and pdr_isqrt.
module point_distance_row_builder #(
    parameter int MAX_POINTS = pdr_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pdr_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pdr_pkg::point_t  point,
    output logic             busy,
    output logic             strobe,
    output pdr_pkg::result_t result
);

    import pdr_pkg::*;

    // Sizes derived from the parameters. The radicand is the sum of squares
    // shifted up by 16 bits, so its root carries 8 fraction bits, padded by
    // one leading zero to an even width.
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = 2 * COORD_BITS + 1;
    localparam int RAD_W  = 2 * COORD_BITS + 18;
    localparam int ROOT_W = RAD_W / 2;
    localparam int XW     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int MW     = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

    // Controller states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_RT   = 3'd4;
    localparam logic [2:0] ST_SELF = 3'd5;
    localparam logic [2:0] ST_FULL = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [COORD_BITS-1:0] nx_reg, nx_next;
    logic [COORD_BITS-1:0] ny_reg, ny_next;
    logic                  strobe_reg, strobe_next;
    result_t               result_reg, result_next;

    logic [COORD_BITS-1:0] mem_x, mem_y;
    logic [COORD_BITS-1:0] dx, dy;
    logic                  sq_go, sq_done;
    logic [SUM_W-1:0]      sq_sum;
    logic                  rt_go, rt_done;
    logic [ROOT_W-1:0]     rt_root;
    logic [XW-1:0]         idx_x, cnt_x;

    // Only the low COORD_BITS of a coordinate count; when COORD_BITS is wider
    // than the field the missing high bits read as zero.
    function automatic logic [COORD_BITS-1:0] take_coord(input logic [COORD_W-1:0] v);
        logic [COORD_BITS+COORD_W-1:0] wide;
        wide = {{COORD_BITS{1'b0}}, v};
        return wide[COORD_BITS-1:0];
    endfunction

    // Magnitude of the difference of two signed coordinates; it always fits
    // in COORD_BITS unsigned bits.
    function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (d[COORD_BITS])
        begin
            d = -d;
        end
        return d[COORD_BITS-1:0];
    endfunction

    // Clamp the root to the width of the distance field.
    function automatic logic [DIST_W-1:0] sat_dist(input logic [ROOT_W-1:0] r);
        logic [MW-1:0] w;
        w = MW'(r);
        if (w > MW'(DIST_MAX))
        begin
            return DIST_MAX;
        end
        return w[DIST_W-1:0];
    endfunction

    pdr_point_mem #(
        .DEPTH (MAX_POINTS),
        .CW    (COORD_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (state_reg == ST_SELF),
        .waddr (count_reg[AW-1:0]),
        .wx    (nx_reg),
        .wy    (ny_reg),
        .re    (state_reg == ST_RD),
        .raddr (idx_reg[AW-1:0]),
        .rx    (mem_x),
        .ry    (mem_y)
    );

    assign dx    = abs_diff(mem_x, nx_reg);
    assign dy    = abs_diff(mem_y, ny_reg);
    assign sq_go = (state_reg == ST_DIFF);
    assign rt_go = (state_reg == ST_SQ) && sq_done;

    pdr_sq_serial #(
        .CW (COORD_BITS)
    ) u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (sq_go),
        .a     (dx),
        .b     (dy),
        .done  (sq_done),
        .sum   (sq_sum)
    );

    pdr_isqrt #(
        .IN_W (RAD_W)
    ) u_rt (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (rt_go),
        .rad   ({1'b0, sq_sum, 16'h0000}),
        .done  (rt_done),
        .root  (rt_root)
    );

    assign idx_x = XW'(idx_reg);
    assign cnt_x = XW'(count_reg);

    // Sequencer: walk the stored points in index order, one distance at a time, then give the
    // self entry, store the new point and return to idle; a full store gives only the error word.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    nx_next  = take_coord(point.x_coord);
                    ny_next  = take_coord(point.y_coord);
                    idx_next = '0;
                    if (count_reg == CNT_W'(MAX_POINTS))
                    begin
                        state_next = ST_FULL;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_SELF;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (sq_done)
                begin
                    state_next = ST_RT;
                end
            end
            ST_RT:
            begin
                if (rt_done)
                begin
                    strobe_next             = 1'b1;
                    result_next.other_index = idx_x[IDX_W-1:0];
                    result_next.new_index   = cnt_x[IDX_W-1:0];
                    result_next.distance_q8 = sat_dist(rt_root);
                    result_next.full_error  = 1'b0;
                    result_next.last        = 1'b0;
                    idx_next                = idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) == count_reg)
                    begin
                        state_next = ST_SELF;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_SELF:
            begin
                strobe_next             = 1'b1;
                result_next.other_index = cnt_x[IDX_W-1:0];
                result_next.new_index   = cnt_x[IDX_W-1:0];
                result_next.distance_q8 = '0;
                result_next.full_error  = 1'b0;
                result_next.last        = 1'b1;
                count_next              = count_reg + CNT_W'(1);
                state_next              = ST_IDLE;
            end
            ST_FULL:
            begin
                strobe_next             = 1'b1;
                result_next.other_index = '0;
                result_next.new_index   = '0;
                result_next.distance_q8 = '0;
                result_next.full_error  = 1'b1;
                result_next.last        = 1'b1;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        result_reg <= result_next;
    end

    // The block takes a new word only when the sequencer is idle; the last
    // result of a row shows in the same cycle that busy drops.
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ----- sv/pdr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the point distance row builder, attached by bind.
// Depends on pdr_pkg and on the top level's ports.
module pdr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             strobe,
    input pdr_pkg::result_t result
);

    import pdr_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the block busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> !busy)
        else $error("block still busy on the last word of a row");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("row word delivered while idle");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.full_error |-> result.last && result.distance_q8 == '0
            && result.other_index == '0 && result.new_index == '0)
        else $error("malformed store-full word");

    a_self_word: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last && !result.full_error |->
            result.other_index == result.new_index && result.distance_q8 == '0)
        else $error("self entry has wrong index or nonzero distance");

endmodule

bind point_distance_row_builder pdr_checker u_pdr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
